FILE: rtl/pds_pkg.sv
// Shared constants, codes and types of the process dispatch scheduler.
package pds_pkg;

   localparam int MaxProcs = 32;
   localparam int SlotW    = $clog2(MaxProcs);
   localparam int CountW   = $clog2(MaxProcs + 1);
   localparam int TimeW    = 32;
   localparam int PendW    = 6;
   localparam int SliceW   = 16;
   localparam int PolW     = 2;
   localparam int StatW    = 2;

   localparam logic [CountW-1:0] MaxCount = CountW'(MaxProcs);

   localparam logic [PolW-1:0] PolFcfs = 2'd0;
   localparam logic [PolW-1:0] PolSrt  = 2'd1;
   localparam logic [PolW-1:0] PolRr   = 2'd2;

   localparam logic [StatW-1:0] StatAdded      = 2'd0;
   localparam logic [StatW-1:0] StatDispatched = 2'd1;
   localparam logic [StatW-1:0] StatNothing    = 2'd2;
   localparam logic [StatW-1:0] StatFull       = 2'd3;

   localparam logic CmdAdd      = 1'b0;
   localparam logic CmdDispatch = 1'b1;

   localparam logic RegPolicy = 1'b0;
   localparam logic RegSlice  = 1'b1;

   localparam logic [PolW-1:0]   PolicyReset = PolFcfs;
   localparam logic [SliceW-1:0] SliceReset  = 16'd10;

   typedef struct packed {
      logic [TimeW-1:0] arrival;
      logic [TimeW-1:0] id;
      logic [TimeW-1:0] remaining;
      logic [TimeW-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [PolW-1:0]  pol;
      logic             found;
      logic [TimeW-1:0] now;
   } sel_ctl_type;

   typedef struct packed {
      logic [StatW-1:0] status;
      logic [TimeW-1:0] chosen_id;
      logic [TimeW-1:0] start_time;
      logic [TimeW-1:0] remaining_before;
      logic [TimeW-1:0] run_length;
      logic             finished;
      logic [TimeW-1:0] end_time;
      logic [PendW-1:0] still_pending;
   } result_type;

   typedef enum logic [2:0] {
      StIdle,
      StScan,
      StPrep,
      StCommit,
      StCount,
      StEmit
   } state_type;

endpackage

FILE: rtl/pds_if.sv
// Request, response and register-write channel interfaces of the scheduler.
interface pds_req_if import pds_pkg::*;;
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [TimeW-1:0] arrival_time;
   logic [TimeW-1:0] proc_id;
   logic [TimeW-1:0] job_length;

   modport source (output valid, cmd, arrival_time, proc_id, job_length, input ready);
   modport sink   (input valid, cmd, arrival_time, proc_id, job_length, output ready);
endinterface

interface pds_rsp_if import pds_pkg::*;;
   logic             valid;
   logic             ready;
   logic [StatW-1:0] status;
   logic [TimeW-1:0] chosen_id;
   logic [TimeW-1:0] start_time;
   logic [TimeW-1:0] remaining_before;
   logic [TimeW-1:0] run_length;
   logic             finished;
   logic [TimeW-1:0] end_time;
   logic [PendW-1:0] still_pending;

   modport source (output valid, status, chosen_id, start_time, remaining_before, run_length,
                   finished, end_time, still_pending, input ready);
   modport sink   (input valid, status, chosen_id, start_time, remaining_before, run_length,
                   finished, end_time, still_pending, output ready);
endinterface

interface pds_csr_if import pds_pkg::*;;
   logic              valid;
   logic              ready;
   logic              index;
   logic [SliceW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/pds_table.sv
// Process table memory: one write port, one registered read port.
module pds_table import pds_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [SlotW-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [SlotW-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MaxProcs];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pds_select.sv
// Shared compare unit: judges one table entry against the best so far.
module pds_select import pds_pkg::*; (
   input  sel_ctl_type ctl,
   input  entry_type   cand,
   input  entry_type   best,
   output logic        take,
   output logic        pend
);

   logic live;
   logic arrived;
   logic order_first;
   logic cand_fresh;
   logic best_fresh;

   always_comb begin
      live        = cand.remaining != '0;
      arrived     = cand.arrival <= ctl.now;
      order_first = (cand.arrival < best.arrival) ||
                    ((cand.arrival == best.arrival) && (cand.id < best.id));
      cand_fresh  = cand.stamp == cand.arrival;
      best_fresh  = best.stamp == best.arrival;
      pend        = live && arrived;
      case (ctl.pol)
         PolSrt: begin
            take = live && arrived &&
                   (!ctl.found || (cand.remaining < best.remaining) ||
                    ((cand.remaining == best.remaining) && order_first));
         end
         PolRr: begin
            take = live &&
                   (!ctl.found || (cand.stamp < best.stamp) ||
                    ((cand.stamp == best.stamp) &&
                     ((cand_fresh && !best_fresh) ||
                      ((cand_fresh == best_fresh) && order_first))));
         end
         default: begin
            take = live && (!ctl.found || order_first);
         end
      endcase
   end

endmodule

FILE: rtl/process_dispatch_scheduler_top.sv
// Process dispatch scheduler top level: sequencer, registers and channel ports.
//
// Channels: req_ch takes add and dispatch commands, rsp_ch returns one result per
// command, csr_ch writes the policy (index 0) and round robin time slice (index 1).
// Every channel transfers at a rising edge with valid and ready both high; csr_ch
// is always ready and is to be written only while no command is in flight, which the
// block itself does not enforce. An add goes through the emit state to its result.
// A dispatch that finds a process walks the stored entries through the single table
// read port twice: once to pick the process with the shared compare unit, once to
// count pending processes. Shortest remaining time walks them once more when it
// finds no arrived process and falls back to arrival order. A new command is taken
// once the previous one has left the sequencer.
// Reset empties the table (entry count zero; the memory keeps its contents), clears
// the current time and sets the policy to first come first served and the time slice to 10.
// Results sit in an output register; a stalled receiver holds it, the next
// command still runs, and the sequencer waits only when both registers are full.
module process_dispatch_scheduler_top import pds_pkg::*; (
   input logic     clock,
   input logic     reset,
   pds_req_if.sink   req_ch,
   pds_rsp_if.source rsp_ch,
   pds_csr_if.sink   csr_ch
);

   state_type         state_ff, state_in;
   logic [CountW-1:0] idx_ff, idx_in;
   logic              cand_vld_ff, cand_vld_in;
   logic [SlotW-1:0]  cand_slot_ff, cand_slot_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [CountW-1:0] pend_ff, pend_in;
   logic [TimeW-1:0]  clock_now_ff, clock_now_in;
   logic [PolW-1:0]   policy_ff, policy_in;
   logic [SliceW-1:0] slice_ff, slice_in;
   logic [PolW-1:0]   scan_pol_ff, scan_pol_in;
   logic              found_ff, found_in;
   logic              out_vld_ff, out_vld_in;
   entry_type         best_ff, best_in;
   logic [SlotW-1:0]  best_slot_ff, best_slot_in;
   logic [TimeW-1:0]  start_ff, start_in;
   logic [TimeW-1:0]  run_ff, run_in;
   result_type        res_ff, res_in;
   result_type        out_ff, out_in;

   logic              wr_en;
   logic [SlotW-1:0]  wr_addr;
   entry_type         wr_data;
   logic [SlotW-1:0]  rd_addr;
   entry_type         rd_data;
   sel_ctl_type       sel_ctl;
   logic              take;
   logic              pend;
   logic              issue;
   logic [TimeW-1:0]  quantum;
   logic [TimeW:0]    end_sum;
   logic [TimeW-1:0]  end_time;
   logic [TimeW-1:0]  remain;

   pds_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sel_ctl = '{pol: scan_pol_ff, found: found_ff, now: clock_now_ff};

   pds_select u_select (
      .ctl  (sel_ctl),
      .cand (rd_data),
      .best (best_ff),
      .take (take),
      .pend (pend)
   );

   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid            = out_vld_ff;
   assign rsp_ch.status           = out_ff.status;
   assign rsp_ch.chosen_id        = out_ff.chosen_id;
   assign rsp_ch.start_time       = out_ff.start_time;
   assign rsp_ch.remaining_before = out_ff.remaining_before;
   assign rsp_ch.run_length       = out_ff.run_length;
   assign rsp_ch.finished         = out_ff.finished;
   assign rsp_ch.end_time         = out_ff.end_time;
   assign rsp_ch.still_pending    = out_ff.still_pending;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cand_vld_in  = 1'b0;
      cand_slot_in = cand_slot_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      clock_now_in = clock_now_ff;
      policy_in    = policy_ff;
      slice_in     = slice_ff;
      scan_pol_in  = scan_pol_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      start_in     = start_ff;
      run_in       = run_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff && !rsp_ch.ready;
      req_ch.ready = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = count_ff[SlotW-1:0];
      wr_data      = '{arrival: req_ch.arrival_time, id: req_ch.proc_id,
                       remaining: req_ch.job_length, stamp: req_ch.arrival_time};
      rd_addr      = idx_ff[SlotW-1:0];
      issue        = idx_ff < count_ff;
      quantum      = (slice_ff == '0) ? TimeW'(1) : {{(TimeW - SliceW){1'b0}}, slice_ff};
      end_sum      = {1'b0, start_ff} + {1'b0, run_ff};
      end_time     = end_sum[TimeW] ? '1 : end_sum[TimeW-1:0];
      remain       = best_ff.remaining - run_ff;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            RegPolicy: policy_in = csr_ch.data[PolW-1:0];
            RegSlice:  slice_in  = csr_ch.data;
         endcase
      end

      unique case (state_ff)
         StIdle: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               res_in = '0;
               if (req_ch.cmd == CmdAdd) begin
                  state_in = StEmit;
                  if (count_ff >= MaxCount) begin
                     res_in.status = StatFull;
                  end else begin
                     res_in.status = StatAdded;
                     wr_en         = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end else begin
                  state_in = StScan;
                  idx_in   = '0;
                  found_in = 1'b0;
                  if (policy_ff == PolSrt || policy_ff == PolRr) begin
                     scan_pol_in = policy_ff;
                  end else begin
                     scan_pol_in = PolFcfs;
                  end
               end
            end
         end
         StScan: begin
            if (issue) begin
               idx_in       = idx_ff + 1'b1;
               cand_vld_in  = 1'b1;
               cand_slot_in = idx_ff[SlotW-1:0];
            end
            if (cand_vld_ff && take) begin
               best_in      = rd_data;
               best_slot_in = cand_slot_ff;
               found_in     = 1'b1;
            end
            if (!issue && !cand_vld_ff) begin
               if (found_ff) begin
                  state_in = StPrep;
               end else if (scan_pol_ff == PolSrt) begin
                  scan_pol_in = PolFcfs;
                  idx_in      = '0;
               end else begin
                  res_in        = '0;
                  res_in.status = StatNothing;
                  state_in      = StEmit;
               end
            end
         end
         StPrep: begin
            start_in = (clock_now_ff < best_ff.arrival) ? best_ff.arrival : clock_now_ff;
            run_in   = best_ff.remaining;
            if (policy_ff == PolRr && best_ff.remaining > quantum) begin
               run_in = quantum;
            end
            state_in = StCommit;
         end
         StCommit: begin
            wr_en                   = 1'b1;
            wr_addr                 = best_slot_ff;
            wr_data                 = '{arrival: best_ff.arrival, id: best_ff.id,
                                        remaining: remain, stamp: end_time};
            clock_now_in            = end_time;
            res_in.status           = StatDispatched;
            res_in.chosen_id        = best_ff.id;
            res_in.start_time       = start_ff;
            res_in.remaining_before = best_ff.remaining;
            res_in.run_length       = run_ff;
            res_in.finished         = remain == '0;
            res_in.end_time         = end_time;
            idx_in                  = '0;
            pend_in                 = '0;
            state_in                = StCount;
         end
         StCount: begin
            if (issue) begin
               idx_in       = idx_ff + 1'b1;
               cand_vld_in  = 1'b1;
               cand_slot_in = idx_ff[SlotW-1:0];
            end
            if (cand_vld_ff && pend) begin
               pend_in = pend_ff + 1'b1;
            end
            if (!issue && !cand_vld_ff) begin
               res_in.still_pending = PendW'(pend_ff);
               state_in             = StEmit;
            end
         end
         StEmit: begin
            if (!out_vld_ff || rsp_ch.ready) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         idx_ff       <= '0;
         cand_vld_ff  <= 1'b0;
         count_ff     <= '0;
         pend_ff      <= '0;
         clock_now_ff <= '0;
         policy_ff    <= PolicyReset;
         slice_ff     <= SliceReset;
         scan_pol_ff  <= PolFcfs;
         found_ff     <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cand_vld_ff  <= cand_vld_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         clock_now_ff <= clock_now_in;
         policy_ff    <= policy_in;
         slice_ff     <= slice_in;
         scan_pol_ff  <= scan_pol_in;
         found_ff     <= found_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_slot_ff <= cand_slot_in;
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      start_ff     <= start_in;
      run_ff       <= run_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
   end

endmodule
